### hw/rtl/ris_pkg.sv
// Package for the replicating image scaler: config bundle, queue item and
// result types, command and register codes, copy-count helper functions.
// No dependencies.
package ris_pkg;

  localparam int SW_BITS  = 11;
  localparam int DIM_BITS = 16;
  localparam int PIX_BITS = 24;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SW_BITS-1:0]  src_width;
    logic [DIM_BITS-1:0] src_height;
    logic [DIM_BITS-1:0] dst_width;
    logic [DIM_BITS-1:0] dst_height;
  } cfg_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [PIX_BITS-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic                row_consumed;
    logic                end_of_frame;
    logic                end_of_line;
    logic [PIX_BITS-1:0] pixel_out;
  } result_t;

  // extra copy for the index whose (i+1) mod k is given
  function automatic logic extra_copy(input logic rem_nz, input logic except_mode,
                                      input logic [DIM_BITS-1:0] idx_mod);
    logic hit;
    hit = (idx_mod == '0);
    extra_copy = rem_nz && (except_mode ? !hit : hit);
  endfunction

  function automatic logic [DIM_BITS-1:0] mod_adv(input logic [DIM_BITS-1:0] m,
                                                  input logic [DIM_BITS-1:0] k);
    logic [DIM_BITS:0] nx;
    nx = {1'b0, m} + 17'd1;
    mod_adv = (nx == {1'b0, k}) ? '0 : nx[DIM_BITS-1:0];
  endfunction

  // (0+1) mod k
  function automatic logic [DIM_BITS-1:0] mod_first(input logic [DIM_BITS-1:0] k);
    mod_first = (k == 16'd1) ? 16'd0 : 16'd1;
  endfunction

endpackage

### hw/rtl/ris_div.sv
// Serial restoring divider, one quotient bit per cycle (17 bits); done pulses
// once the last quotient bit is in. Used by the setup sequencer in ris_core. Depends on ris_pkg.
module ris_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ris_pkg::DIM_BITS:0]     dividend,
  input  logic [ris_pkg::DIM_BITS-1:0]   divisor,
  output logic                           done,
  output logic [ris_pkg::DIM_BITS:0]     quotient,
  output logic [ris_pkg::DIM_BITS-1:0]   remainder
);

  logic [ris_pkg::DIM_BITS:0]   rem;
  logic [ris_pkg::DIM_BITS:0]   quo;
  logic [ris_pkg::DIM_BITS-1:0] dvs;
  logic [4:0]                   cnt;
  logic                         running;
  logic [ris_pkg::DIM_BITS:0]   rem_sh;

  assign rem_sh    = {rem[ris_pkg::DIM_BITS-1:0], quo[ris_pkg::DIM_BITS]};
  assign quotient  = quo;
  assign remainder = rem[ris_pkg::DIM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= 5'(ris_pkg::DIM_BITS + 1);
      rem     <= '0;
      quo     <= dividend;
      dvs     <= divisor;
    end else begin
      done <= 1'b0;
      if (running) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[ris_pkg::DIM_BITS-1:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[ris_pkg::DIM_BITS-1:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/ris_fifo.sv
// Two-entry queue between the accepting front and the executing back end.
// Depends on ris_pkg.
module ris_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ris_pkg::item_t push_item,
  output logic           full,
  output logic           q_valid,
  output ris_pkg::item_t q_item,
  input  logic           pop
);

  ris_pkg::item_t slots [2];
  logic           wp, rp;
  logic [1:0]     count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wp] <= push_item;
        wp        <= !wp;
      end
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/ris_core.sv
// Back end: per-frame setup (divisions on the shared serial divider), line
// store, column/row replication counters and the output register.
// Depends on ris_pkg and ris_div.
module ris_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  ris_pkg::cfg_t    cfg,
  input  logic             cfg_we,
  input  logic             q_valid,
  input  ris_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  output ris_pkg::result_t out_data,
  input  logic             out_ready
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DB = ris_pkg::DIM_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ} state_t;
  state_t state;

  logic [ris_pkg::PIX_BITS-1:0] line_store [MAX_WIDTH];
  logic [ris_pkg::PIX_BITS-1:0] rd_data;

  // effective sizes
  logic [CW-1:0] w, wm1;
  logic [DB-1:0] w16, sh, dw, dh;

  // setup results
  logic [DB-1:0] qc, remc, d2c, kc, qr, remr, d2r, kr;
  logic          exc, exr;
  logic          dirty, div_busy;
  logic [2:0]    step;

  // frame counters
  logic [CW-1:0] sc, fill;
  logic [DB-1:0] colmod, rowmod, srow, rci, pci, ocol, orow;

  // divider
  logic          div_start, div_done;
  logic [DB:0]   div_a, div_q;
  logic [DB-1:0] div_b, div_r;

  logic [DB:0]   cp_c, cp_r;
  logic          inw, srow_more;
  logic [CW-1:0] fill_eff, fill_inc;
  logic [DB:0]   ocol_inc, orow_inc;

  always_comb begin
    if (cfg.src_width == '0) w = CW'(1);
    else if (32'(cfg.src_width) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(cfg.src_width);
    wm1 = w - CW'(1);
    w16 = DB'(w);
    sh  = (cfg.src_height == '0) ? DB'(1) : cfg.src_height;
    dw  = (cfg.dst_width  == '0) ? DB'(1) : cfg.dst_width;
    dh  = (cfg.dst_height == '0) ? DB'(1) : cfg.dst_height;
  end

  always_comb begin
    case (step)
      3'd0:    begin div_a = {1'b0, dw};      div_b = w16;        end
      3'd1:    begin div_a = {1'b0, w16};     div_b = remc;       end
      3'd2:    begin div_a = {1'b0, w16};     div_b = w16 - remc; end
      3'd3:    begin div_a = (DB+1)'(sc) + 17'd1; div_b = kc;     end
      3'd4:    begin div_a = {1'b0, dh};      div_b = sh;         end
      3'd5:    begin div_a = {1'b0, sh};      div_b = remr;       end
      3'd6:    begin div_a = {1'b0, sh};      div_b = sh - remr;  end
      default: begin div_a = {1'b0, srow} + 17'd1; div_b = kr;    end
    endcase
  end

  assign div_start = dirty && !div_busy && !cfg_we && (state == ST_IDLE);

  ris_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign cp_c      = {1'b0, qc} + (DB+1)'(ris_pkg::extra_copy(remc != '0, exc, colmod));
  assign cp_r      = {1'b0, qr} + (DB+1)'(ris_pkg::extra_copy(remr != '0, exr, rowmod));
  assign inw       = sc < w;
  assign srow_more = ({1'b0, srow} + 17'd1) < {1'b0, sh};
  assign fill_eff  = (fill >= w) ? '0 : fill;
  assign fill_inc  = fill_eff + CW'(1);
  assign ocol_inc  = {1'b0, ocol} + 17'd1;
  assign orow_inc  = {1'b0, orow} + 17'd1;

  assign q_pop = (state == ST_IDLE) && q_valid && !dirty && !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == ris_pkg::CMD_PUSH) line_store[fill_eff[AW-1:0]] <= q_item.pixel;
    if (state == ST_SCAN && !(inw && {1'b0, pci} >= cp_c))
      rd_data <= line_store[inw ? sc[AW-1:0] : wm1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 1'b1;
      div_busy  <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      sc <= '0; fill <= '0; srow <= '0; rci <= '0; pci <= '0;
      ocol <= '0; orow <= '0; colmod <= '0; rowmod <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;

      // setup sequencer
      if (cfg_we) begin
        dirty    <= 1'b1;
        div_busy <= 1'b0;
        step     <= '0;
      end else if (div_start) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_done) begin
        div_busy <= 1'b0;
        step     <= step + 3'd1;
        if (step == 3'd7) dirty <= 1'b0;
        case (step)
          3'd0: begin qc <= div_q[DB-1:0]; remc <= div_r; end
          3'd1: d2c <= div_q[DB-1:0];
          3'd2: begin
            kc  <= (d2c >= 16'd2) ? d2c : div_q[DB-1:0];
            exc <= (d2c < 16'd2);
          end
          3'd3: colmod <= div_r;
          3'd4: begin qr <= div_q[DB-1:0]; remr <= div_r; end
          3'd5: d2r <= div_q[DB-1:0];
          3'd6: begin
            kr  <= (d2r >= 16'd2) ? d2r : div_q[DB-1:0];
            exr <= (d2r < 16'd2);
          end
          default: rowmod <= div_r;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.cmd == ris_pkg::CMD_PULL) begin
              state <= ST_SCAN;
            end else if (fill_inc >= w) begin
              fill <= '0;
              // source row with no copies: drop it
              if (cp_r == '0 && srow_more) begin
                srow      <= srow + DB'(1);
                rowmod    <= ris_pkg::mod_adv(rowmod, kr);
                rci       <= '0;
                out_valid <= 1'b1;
                out_data  <= '{row_consumed: 1'b1, end_of_frame: 1'b0,
                               end_of_line: 1'b0, pixel_out: '0};
              end
            end else begin
              fill <= fill_inc;
            end
          end
        end
        ST_SCAN: begin
          // skip one exhausted column per cycle
          if (inw && {1'b0, pci} >= cp_c) begin
            sc     <= sc + CW'(1);
            colmod <= ris_pkg::mod_adv(colmod, kc);
            pci    <= '0;
          end else begin
            if (inw) pci <= pci + DB'(1);
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state              <= ST_IDLE;
          out_valid          <= 1'b1;
          out_data.pixel_out <= rd_data;
          out_data.end_of_frame <= 1'b0;
          out_data.row_consumed <= 1'b0;
          if (ocol_inc >= {1'b0, dw}) begin
            out_data.end_of_line <= 1'b1;
            ocol   <= '0;
            sc     <= '0;
            colmod <= ris_pkg::mod_first(kc);
            pci    <= '0;
            if (orow_inc >= {1'b0, dh}) begin
              out_data.end_of_frame <= 1'b1;
              orow   <= '0;
              srow   <= '0;
              rowmod <= ris_pkg::mod_first(kr);
              rci    <= '0;
              fill   <= '0;
            end else begin
              orow <= orow_inc[DB-1:0];
              if ({1'b0, (rci == 16'hFFFF) ? rci : rci + DB'(1)} >= cp_r && srow_more) begin
                srow   <= srow + DB'(1);
                rowmod <= ris_pkg::mod_adv(rowmod, kr);
                rci    <= '0;
                out_data.row_consumed <= 1'b1;
              end else if (rci != 16'hFFFF) begin
                rci <= rci + DB'(1);
              end
            end
          end else begin
            out_data.end_of_line <= 1'b0;
            ocol <= ocol_inc[DB-1:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/replicating_image_scaler.sv
// Replicating image scaler. Push: the pixel waits in the queue and is written to the line
// store when ris_core pops it (a dropped row's result is registered then); pull: the core
// skips zero-copy source columns (column scan in ris_core), reads the store, registers the result.
// One item in flight in the back end; the next leaves the 2-entry queue once the result is taken.
// Reset (sync, rst high): registers to 1, counters to 0, then a setup of 8 serial
// divisions; the same setup follows every config write.
module replicating_image_scaler #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] pixel
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] pixel_out
  output logic        m_tlast,   // end_of_line
  output logic [1:0]  m_tuser    // [0] end_of_frame, [1] row_consumed
);

  ris_pkg::cfg_t    cfg;
  ris_pkg::item_t   in_item, q_item;
  ris_pkg::result_t res;
  logic             full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{src_width: 11'd1, src_height: 16'd1, dst_width: 16'd1, dst_height: 16'd1};
    end else if (cfg_we) begin
      case (ris_pkg::reg_idx_t'(cfg_index))
        ris_pkg::REG_SRC_WIDTH:  cfg.src_width  <= cfg_wdata[10:0];
        ris_pkg::REG_SRC_HEIGHT: cfg.src_height <= cfg_wdata;
        ris_pkg::REG_DST_WIDTH:  cfg.dst_width  <= cfg_wdata;
        ris_pkg::REG_DST_HEIGHT: cfg.dst_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = !full;
  assign in_item  = '{cmd: ris_pkg::cmd_t'(s_tuser), pixel: s_tdata};

  ris_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_item (in_item),
    .full      (full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  ris_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_we    (cfg_we),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_data  (res),
    .out_ready (m_tready)
  );

  assign m_tdata = res.pixel_out;
  assign m_tlast = res.end_of_line;
  assign m_tuser = {res.row_consumed, res.end_of_frame};

  a_eof_ends_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast) else $error("frame end without line end");
  a_eof_no_rc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("row_consumed at frame end");
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> q_valid) else $error("accepted transfer lost");

endmodule

### verif/testbench.sv
// Self-checking testbench for replicating_image_scaler: random and directed
// push/pull streams over many scale settings, checked against a scoreboard.
// Depends on ris_pkg and the scaler RTL.
module testbench;

  class scale_scoreboard;
    int unsigned sw, sh, dw, dh;
    logic [23:0] store [1024];
    bit written [1024];
    int unsigned src_row, src_col, row_copy, pix_copy;
    int unsigned out_col, out_row, col_ph, row_ph, fill;
    logic [23:0] last_px;
    ris_pkg::result_t pending [$];
    int errors;

    function new();
      sw = 1; sh = 1; dw = 1; dh = 1;
      foreach (store[i]) store[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      src_row = 0; src_col = 0; row_copy = 0; pix_copy = 0;
      out_col = 0; out_row = 0; col_ph = 0; row_ph = 0; fill = 0;
      last_px = '0;
      errors = 0;
    endfunction

    function void write_reg(ris_pkg::reg_idx_t r, logic [15:0] v);
      case (r)
        ris_pkg::REG_SRC_WIDTH:  sw = v[10:0];
        ris_pkg::REG_SRC_HEIGHT: sh = v;
        ris_pkg::REG_DST_WIDTH:  dw = v;
        ris_pkg::REG_DST_HEIGHT: dh = v;
        default: ;
      endcase
    endfunction

    function int unsigned copy_count(int unsigned i, int unsigned s, int unsigned d);
      int unsigned q, rem, k;
      q = d / s;
      rem = d % s;
      if (rem == 0) return q;
      if (s / rem >= 2) begin
        k = s / rem;
        return q + (((i + 1) % k == 0) ? 1 : 0);
      end
      k = s / (s - rem);
      return q + (((i + 1) % k != 0) ? 1 : 0);
    endfunction

    // true when the next pull reads a store entry that has been written
    function bit pull_safe();
      int unsigned w, ow, c, pc;
      w = (sw == 0) ? 1 : (sw > 1024) ? 1024 : sw;
      ow = (dw == 0) ? 1 : dw;
      c = src_col;
      pc = pix_copy;
      while (c < w) begin
        if (pc < copy_count(c, w, ow)) break;
        c++;
        pc = 0;
      end
      return written[(c < w) ? c : w - 1];
    endfunction

    // returns {row_consumed, end_of_frame} of the predicted result
    function bit [1:0] note_input(ris_pkg::cmd_t c, logic [23:0] px);
      int unsigned w, h, ow, oh;
      ris_pkg::result_t r;
      w = (sw == 0) ? 1 : (sw > 1024) ? 1024 : sw;
      h = (sh == 0) ? 1 : sh;
      ow = (dw == 0) ? 1 : dw;
      oh = (dh == 0) ? 1 : dh;
      r = '0;
      if (c == ris_pkg::CMD_PUSH) begin
        if (fill >= w) fill = 0;
        store[fill] = px;
        written[fill] = 1'b1;
        fill++;
        if (fill >= w) begin
          fill = 0;
          row_ph = copy_count(src_row, h, oh);
          // row with no copies is dropped right away
          if (row_ph == 0 && src_row + 1 < h) begin
            src_row++;
            row_copy = 0;
            r.row_consumed = 1'b1;
            pending.push_back(r);
            return 2'b10;
          end
        end
        return 2'b00;
      end
      while (src_col < w) begin
        col_ph = copy_count(src_col, w, ow);
        if (pix_copy < col_ph) break;
        src_col++;
        pix_copy = 0;
      end
      if (src_col < w) begin
        last_px = store[src_col];
        pix_copy++;
      end else begin
        last_px = store[w-1];
      end
      r.pixel_out = last_px;
      out_col++;
      if (out_col >= ow) begin
        r.end_of_line = 1'b1;
        out_col = 0;
        src_col = 0;
        pix_copy = 0;
        out_row++;
        if (row_copy < 16'hFFFF) row_copy++;
        if (out_row >= oh) begin
          r.end_of_frame = 1'b1;
          out_row = 0; src_row = 0; row_copy = 0; fill = 0;
        end else begin
          row_ph = copy_count(src_row, h, oh);
          if (row_copy >= row_ph && src_row + 1 < h) begin
            src_row++;
            row_copy = 0;
            r.row_consumed = 1'b1;
          end
        end
      end
      pending.push_back(r);
      return {r.row_consumed, r.end_of_frame};
    endfunction

    function void check_result(ris_pkg::result_t got);
      ris_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.pixel_out !== exp_r.pixel_out || got.end_of_line !== exp_r.end_of_line ||
          got.end_of_frame !== exp_r.end_of_frame ||
          got.row_consumed !== exp_r.row_consumed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: pixel %h/%h eol %b/%b eof %b/%b rc %b/%b (exp/got)",
                   exp_r.pixel_out, got.pixel_out, exp_r.end_of_line, got.end_of_line,
                   exp_r.end_of_frame, got.end_of_frame,
                   exp_r.row_consumed, got.row_consumed);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  scale_scoreboard sb;

  replicating_image_scaler DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stall before each transfer
  initial begin
    int unsigned stall;
    ris_pkg::result_t got;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      got.pixel_out = m_tdata;
      got.end_of_line = m_tlast;
      got.end_of_frame = m_tuser[0];
      got.row_consumed = m_tuser[1];
      sb.check_result(got);
    end
  end

  task automatic send(ris_pkg::cmd_t c, logic [23:0] px, output bit [1:0] flags);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= px;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    flags = sb.note_input(c, px);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
    logic [15:0] vals [4];
    vals = '{a, b, c, d};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(ris_pkg::reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_pixel(bit directed);
    logic [23:0] corner [4];
    corner = '{24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
    return directed ? corner[$urandom_range(0, 3)] : 24'($urandom());
  endfunction

  // rows pushed in full, then pulled until the row is used up
  task automatic run_frames(int unsigned budget, bit directed);
    int unsigned sent;
    bit [1:0] fl;
    ris_pkg::cmd_t c;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        c = ris_pkg::cmd_t'($urandom_range(0, 1));
        // a stray pull only where the entry it reads has been written
        if (c == ris_pkg::CMD_PULL && !sb.pull_safe()) c = ris_pkg::CMD_PUSH;
        send(c, pick_pixel(directed), fl);
        sent++;
      end else begin
        fl = 0;
        do begin
          send(ris_pkg::CMD_PUSH, pick_pixel(directed), fl);
          sent++;
        end while (sb.fill != 0 && sent < budget);
        while (fl == 0 && sent < budget) begin
          send(ris_pkg::CMD_PULL, '0, fl);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned cfgs [12][4];
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: row drops, column skips, short rows, missing rows
    configure(16'd5, 16'd7, 16'd3, 16'd3);
    run_frames(25, 1'b1);
    settle();

    cfgs = '{'{4, 3, 7, 5}, '{3, 5, 2, 2}, '{1, 1, 1, 1}, '{0, 0, 0, 0},
             '{5, 4, 5, 4}, '{7, 3, 16, 9}, '{1024, 2, 1, 3}, '{2047, 1, 3, 2},
             '{6, 65535, 65535, 65535}, '{8, 2, 65535, 1}, '{2, 9, 1, 65535},
             '{1, 65535, 1, 2}};
    foreach (cfgs[i]) begin
      configure(16'(cfgs[i][0]), 16'(cfgs[i][1]), 16'(cfgs[i][2]), 16'(cfgs[i][3]));
      run_frames(50, 1'b0);
      settle();
    end
    for (int i = 0; i < 10; i++) begin
      configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)));
      run_frames(45, 1'b0);
      if (i == 4) begin
        // mid-frame change after the pending results have drained
        settle();
        configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)));
        run_frames(40, 1'b0);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/ris_pkg.sv
hw/rtl/ris_div.sv
hw/rtl/ris_fifo.sv
hw/rtl/ris_core.sv
hw/rtl/replicating_image_scaler.sv
verif/testbench.sv
